FILE: rtl/efr_pkg.sv
// ============================================================================
// efr_pkg
// Shared types, constants and the CRC-8 byte update for the escaped frame
// receiver.
// ============================================================================
`default_nettype none

package efr_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [7:0] ESC_XOR_MASK  = 8'h20;
    localparam logic [7:0] DELIM_RESET   = 8'hFE;
    localparam logic [7:0] ESCAPE_RESET  = 8'hFD;
    localparam logic [7:0] POLY_RESET    = 8'h8C;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    typedef enum logic [1:0] {
        CFG_DELIM  = 2'd0,
        CFG_ESCAPE = 2'd1,
        CFG_POLY   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_CRC  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort;
    } t_in_word;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
    } t_out_word;

    // Reflected CRC-8, one byte, bitwise.
    function automatic logic [7:0] crc8_update(
        input logic [7:0] r,
        input logic [7:0] d,
        input logic [7:0] poly
    );
        logic [7:0] v;
        v = r ^ d;
        for (int i = 0; i < 8; i++) begin
            if (v[0]) begin
                v = (v >> 1) ^ poly;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/escaped_frame_receiver_crc8.sv
// ============================================================================
// escaped_frame_receiver_crc8
// Byte-stuffed frame receiver with delimiter sync, escape decoding, one-word
// payload delay and reflected CRC-8 frame check.
// ============================================================================
//
//  Channel  | Handshake                    | Word
//  ---------+------------------------------+-----------------------------
//  in       | i_in_valid / o_in_stall      | t_in_word  (rx_byte, abort)
//  out      | o_out_valid / i_out_stall    | t_out_word (kind, byte, len)
//  cfg      | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
//  One word per cycle while o_in_stall is low; frame state and CRC update are
//  combinational, the result is registered in the output or skid register.
//  An output register plus one skid register: input keeps flowing while a
//  result waits; o_in_stall rises only when the skid register is occupied.
//  Reset (synchronous, active low) restores register defaults, drops sync
//  and empties the output stages.
// ============================================================================
`default_nettype none

module escaped_frame_receiver_crc8
    import efr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,

    input  wire logic      i_in_valid,
    input  wire t_in_word  i_in_data,
    output logic           o_in_stall,

    output logic           o_out_valid,
    output t_out_word      o_out_data,
    input  wire logic      i_out_stall,

    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0]       r_delim, r_escape, r_poly;

    logic             r_in_sync,    n_in_sync;
    logic             r_esc,        n_esc;
    logic [7:0]       r_crc,        n_crc;
    logic [CNT_W-1:0] r_count,      n_count;
    logic [7:0]       r_held,       n_held;
    logic             r_overflowed, n_overflowed;

    logic             r_out_valid;
    t_out_word        r_out;
    logic             r_skid_valid;
    t_out_word        r_skid;

    logic             in_accept;
    logic             out_take;
    logic             res_valid;
    t_out_word        res;
    logic [7:0]       dec_byte;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim  <= DELIM_RESET;
            r_escape <= ESCAPE_RESET;
            r_poly   <= POLY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELIM:  r_delim  <= i_cfg_data;
                CFG_ESCAPE: r_escape <= i_cfg_data;
                CFG_POLY:   r_poly   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame state
    always_comb begin
        n_in_sync    = r_in_sync;
        n_esc        = r_esc;
        n_crc        = r_crc;
        n_count      = r_count;
        n_held       = r_held;
        n_overflowed = r_overflowed;
        res_valid    = 1'b0;
        res          = '0;
        dec_byte     = r_esc ? (i_in_data.rx_byte ^ ESC_XOR_MASK) : i_in_data.rx_byte;

        if (in_accept) begin
            if (i_in_data.abort) begin
                n_in_sync    = 1'b0;
                n_esc        = 1'b0;
                n_crc        = '0;
                n_count      = '0;
                n_held       = '0;
                n_overflowed = 1'b0;
            end else if (!r_in_sync) begin
                if (i_in_data.rx_byte == r_delim) begin
                    n_in_sync    = 1'b1;
                    n_esc        = 1'b0;
                    n_crc        = '0;
                    n_count      = '0;
                    n_held       = '0;
                    n_overflowed = 1'b0;
                end
            end else if (i_in_data.rx_byte == r_delim) begin
                if (r_count != '0) begin
                    res_valid = 1'b1;
                    if (r_overflowed) begin
                        res.kind = KIND_OVERFLOW;
                    end else if (r_crc == '0) begin
                        res.kind = KIND_GOOD;
                    end else begin
                        res.kind = KIND_BAD_CRC;
                    end
                    res.payload_length = 8'(r_count - CNT_W'(1));
                    n_esc        = 1'b0;
                    n_crc        = '0;
                    n_count      = '0;
                    n_held       = '0;
                    n_overflowed = 1'b0;
                end
            end else if (i_in_data.rx_byte == r_escape) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (!r_overflowed) begin
                    if (r_count != '0) begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = r_held;
                    end
                    if (r_count >= CNT_MAX) begin
                        n_overflowed = 1'b1;
                    end else begin
                        n_crc   = crc8_update(r_crc, dec_byte, r_poly);
                        n_held  = dec_byte;
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync    <= 1'b0;
            r_esc        <= 1'b0;
            r_crc        <= '0;
            r_count      <= '0;
            r_held       <= '0;
            r_overflowed <= 1'b0;
        end else begin
            r_in_sync    <= n_in_sync;
            r_esc        <= n_esc;
            r_crc        <= n_crc;
            r_count      <= n_count;
            r_held       <= n_held;
            r_overflowed <= n_overflowed;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held while output register empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("frame byte count beyond buffer size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflowed |-> (r_count == CNT_MAX))
        else $error("overflow flagged with buffer not full");

    a_nosync_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_sync |-> (r_count == '0 && !r_esc && !r_overflowed))
        else $error("frame state live while searching for delimiter");

    a_end_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_PAYLOAD) |-> (r_out.payload_byte == '0))
        else $error("frame end word carries a payload byte");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for escaped_frame_receiver_crc8. Drives raw line words
// through the valid/stall input, decodes the same words in a local copy of the
// frame state, and checks every output word against that copy. Covers sync
// search, escapes, CRC verdicts, frame length limit, abort, register settings
// and output back-pressure under random gaps on both sides.
// ============================================================================

module tb;
    import efr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_word   i_in_data;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_data;
    logic       i_out_stall;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    // local copy of registers and frame state
    logic [7:0] cfg_delim;
    logic [7:0] cfg_esc;
    logic [7:0] cfg_poly;
    logic       synced;
    logic       esc_pending;
    logic       overflowed;
    logic [7:0] crc_acc;
    logic [7:0] held_byte;
    logic [8:0] frame_cnt;

    t_out_word  expected_words[$];
    logic [7:0] frame_buf[$];

    bit tx_idle_en;
    bit rx_idle_en;
    int hold_seq;
    int quiet_cycles;
    int n_words;
    int n_errors;
    int n_cfg;
    int n_payload;
    int n_good;
    int n_bad;
    int n_ovf;

    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    escaped_frame_receiver_crc8 i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // reflected CRC-8, bit serial
    function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] v;
        logic       lsb;
        v = acc ^ d;
        repeat (8) begin
            lsb = v[0];
            v   = {1'b0, v[7:1]} ^ (lsb ? cfg_poly : 8'h00);
        end
        return v;
    endfunction

    function automatic void clear_frame();
        esc_pending = 1'b0;
        crc_acc     = 8'h00;
        frame_cnt   = 9'd0;
        held_byte   = 8'h00;
        overflowed  = 1'b0;
    endfunction

    function automatic void decode_word(input logic [7:0] b, input logic ab);
        t_out_word  w;
        logic [7:0] d;
        if (ab) begin
            synced = 1'b0;
            clear_frame();
            return;
        end
        if (!synced) begin
            if (b == cfg_delim) begin
                synced = 1'b1;
                clear_frame();
            end
            return;
        end
        if (b == cfg_delim) begin
            if (frame_cnt == 9'd0) return;
            if (overflowed) begin
                w.kind = KIND_OVERFLOW;
            end else if (crc_acc == 8'h00) begin
                w.kind = KIND_GOOD;
            end else begin
                w.kind = KIND_BAD_CRC;
            end
            w.payload_byte   = 8'h00;
            w.payload_length = 8'(frame_cnt - 9'd1);
            expected_words.push_back(w);
            clear_frame();
            return;
        end
        if (b == cfg_esc) begin
            esc_pending = 1'b1;
            return;
        end
        d = esc_pending ? (b ^ ESC_XOR_MASK) : b;
        esc_pending = 1'b0;
        if (overflowed) return;
        if (frame_cnt != 9'd0) begin
            w.kind           = KIND_PAYLOAD;
            w.payload_byte   = held_byte;
            w.payload_length = 8'h00;
            expected_words.push_back(w);
        end
        if (frame_cnt >= 9'(MAX_FRAME_BYTES)) begin
            overflowed = 1'b1;
            return;
        end
        crc_acc   = crc_next(crc_acc, d);
        held_byte = d;
        frame_cnt = frame_cnt + 9'd1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 40) begin
            $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (expected_words.size() == 0) begin
            report_mismatch("word with nothing pending, kind", got.kind, 0);
            return;
        end
        want = expected_words.pop_front();
        if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.payload_byte != want.payload_byte) begin
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        end
        if (got.payload_length != want.payload_length) begin
            report_mismatch("payload_length", got.payload_length, want.payload_length);
        end
        case (got.kind)
            KIND_PAYLOAD:  n_payload++;
            KIND_GOOD:     n_good++;
            KIND_BAD_CRC:  n_bad++;
            default:       n_ovf++;
        endcase
    endtask

    // output side: check at the falling edge, word is taken at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            check_word(o_out_data);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: %0d cycles without progress", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver stall: random gaps, plus a long hold-off on request
    initial begin
        int gap;
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                gap = rx_idle_en ? pick_gap() : 0;
                stall_left = (gap > 0) ? gap - 1 : 0;
                i_out_stall <= (gap > 0);
            end
        end
    end

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_word(input logic [7:0] b, input logic ab);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{rx_byte: b, abort: ab};
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        decode_word(b, ab);
        n_words++;
        @(posedge i_clk);
    endtask

    task automatic send_stuffed(input logic [7:0] x);
        if (x == cfg_delim || x == cfg_esc) begin
            send_word(cfg_esc, 1'b0);
            send_word(x ^ ESC_XOR_MASK, 1'b0);
        end else begin
            send_word(x, 1'b0);
        end
    endtask

    // frame_buf, then its CRC byte, then the closing delimiter
    task automatic send_frame(input bit corrupt);
        logic [7:0] acc;
        acc = 8'h00;
        foreach (frame_buf[i]) begin
            acc = crc_next(acc, frame_buf[i]);
            send_stuffed(frame_buf[i]);
        end
        if (corrupt) acc = acc ^ 8'($urandom_range(1, 255));
        send_stuffed(acc);
        send_word(cfg_delim, 1'b0);
    endtask

    task automatic fill_random(input int len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(input t_cfg_idx idx, input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_DELIM:  cfg_delim = v;
            CFG_ESCAPE: cfg_esc   = v;
            default:    cfg_poly  = v;
        endcase
        n_cfg++;
    endtask

    task automatic apply_settings(input logic [7:0] delim, input logic [7:0] esc,
                                  input logic [7:0] poly);
        drain();
        cfg_write(CFG_DELIM, delim);
        cfg_write(CFG_ESCAPE, esc);
        cfg_write(CFG_POLY, poly);
        i_cfg_we <= 1'b0;
    endtask

    task automatic traffic_step();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            if ($urandom_range(0, 1) == 1) send_word(cfg_delim, 1'b0);
            len = ($urandom_range(0, 149) == 0) ? $urandom_range(200, 262)
                                                : $urandom_range(0, 12);
            fill_random(len);
            send_frame($urandom_range(0, 4) == 0);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 6)) send_word(8'($urandom), 1'b0);
        end else if (pick < 87) begin
            send_word(8'($urandom), 1'b1);
            if ($urandom_range(0, 3) != 0) send_word(cfg_delim, 1'b0);
        end else if (pick < 94) begin
            // frame cut short by escape + delimiter
            fill_random($urandom_range(1, 5));
            foreach (frame_buf[i]) send_stuffed(frame_buf[i]);
            send_word(cfg_esc, 1'b0);
            send_word(cfg_delim, 1'b0);
        end else begin
            send_word(cfg_esc, 1'b0);
            send_word(cfg_esc, 1'b0);
            send_word(8'($urandom), 1'b0);
            fill_random($urandom_range(0, 4));
            send_frame($urandom_range(0, 1) == 1);
        end
    endtask

    task automatic run_traffic(input int count);
        int target;
        target = n_words + count;
        while (n_words < target) traffic_step();
    endtask

    task automatic test_directed_cases();
        send_word(8'h41, 1'b0);
        send_word(cfg_esc, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(cfg_delim, 1'b0);
        frame_buf = '{8'h00, 8'hFF, 8'hFE, 8'hFD};
        send_frame(1'b0);
        // empty-frame delimiter keeps the pending escape
        send_word(cfg_esc, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(cfg_esc, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(cfg_esc, 1'b0);
        send_word(cfg_esc, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(8'h10, 1'b0);
        send_word(8'h20, 1'b0);
        send_word(cfg_delim, 1'b1);
        send_word(8'h30, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(8'h07, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(cfg_delim, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    task automatic test_frame_length_limit();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_word(cfg_delim, 1'b0);
        fill_random(MAX_FRAME_BYTES - 1);
        send_frame(1'b0);
        fill_random(MAX_FRAME_BYTES + 2);
        send_frame(1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_register_settings();
        apply_settings(8'h00, 8'hFF, 8'h00);
        run_traffic(80);
        apply_settings(8'hFF, 8'h00, 8'hFF);
        run_traffic(80);
        apply_settings(8'h7E, 8'h7E, 8'h31);
        run_traffic(80);
        repeat (2) begin
            apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
            run_traffic(80);
        end
        apply_settings(DELIM_RESET, ESCAPE_RESET, POLY_RESET);
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_word(cfg_delim, 1'b0);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        hold_seq++;
        @(posedge i_clk);
        fill_random(30);
        send_frame(1'b0);
        drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_traffic(250);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_DELIM;
        i_cfg_data <= 8'h00;
        cfg_delim  = DELIM_RESET;
        cfg_esc    = ESCAPE_RESET;
        cfg_poly   = POLY_RESET;
        synced     = 1'b0;
        clear_frame();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_frame_length_limit();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();
        drain();

        $display("Covered %0d line words across %0d register writes and %0d payload bytes",
                 n_words, n_cfg, n_payload);
        $display("Frame ends seen: %0d good, %0d bad CRC, %0d overflow; %0d mismatches",
                 n_good, n_bad, n_ovf, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
